>>> src/ptts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; every other file imports this package.
package ptts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int RESULT_CAP     = 16;
  localparam int SLOT_IDX_W     = 5;
  localparam int CD_W           = 17;
  localparam int PER_W          = 16;
  localparam int TAG_W          = 8;
  localparam int FAULT_W        = 2;
  localparam int CNT_W          = $clog2(RESULT_CAP + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_OVERLOAD = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_FULL     = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_ZERO_PER = 2'd3;

  typedef struct packed {
    logic             opcode;
    logic [PER_W-1:0] start_delay;
    logic [PER_W-1:0] task_period;
    logic [TAG_W-1:0] task_tag;
    logic             task_busy;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [TAG_W-1:0]      due_tag;
    logic                  due_valid;
    logic [FAULT_W-1:0]    fault_code;
    logic                  last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CD_W-1:0]  cd;
    logic [PER_W-1:0] per;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture accepted transaction
    logic add_zero;   // reject add, zero period
    logic add_place;  // write entry at scan index, report it
    logic add_full;   // reject add, table full
    logic scan_next;  // advance free-slot scan
    logic rd_issue;   // read table entry at walk index
    logic proc;       // update entry held in read stage
    logic flush;      // emit closing result of a tick
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic period_zero;
    logic cur_free;
    logic idx_last;
    logic s1_v;
    logic s1_needs_out;
    logic rd_done;
    logic out_free;
  } sts_t;

endpackage

>>> src/ptts_ctrl.sv
// Sequencing state machine for the tick scheduler.
// Depends on ptts_pkg; drives commands into ptts_dp.
module ptts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_opcode,
  output logic           in_stall,
  input  ptts_pkg::sts_t sts,
  output ptts_pkg::cmd_t cmd
);
  import ptts_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ADD   = 2'd1;
  localparam logic [1:0] S_TICK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       adv;

  assign in_stall = (state_r != S_IDLE);

  // read stage may advance unless it must emit into a full output register
  assign adv = !sts.s1_v || !sts.s1_needs_out || sts.out_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_opcode == OP_TICK) ? S_TICK : S_ADD;
        end
      end
      S_ADD: begin
        if (sts.period_zero) begin
          if (sts.out_free) begin
            cmd.add_zero = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.cur_free) begin
          if (sts.out_free) begin
            cmd.add_place = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (sts.idx_last) begin
          if (sts.out_free) begin
            cmd.add_full = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_TICK: begin
        cmd.proc     = sts.s1_v && adv;
        cmd.rd_issue = adv && !sts.rd_done;
        if (sts.rd_done && (!sts.s1_v || adv)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/ptts_dp.sv
// Datapath: task table memory, used flags, fault register, result staging.
// Depends on ptts_pkg; commanded by ptts_ctrl.
module ptts_dp #(
  parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptts_pkg::in_item_t  in_data,
  input  ptts_pkg::cmd_t      cmd,
  output ptts_pkg::sts_t      sts,
  input  logic                out_stall,
  output logic                out_valid,
  output ptts_pkg::out_item_t out_data
);
  import ptts_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);

  entry_t mem [TASK_SLOTS];
  entry_t rd_q;

  in_item_t              item_r;
  logic [TASK_SLOTS-1:0] used_r;
  logic [FAULT_W-1:0]    fault_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic                  s1_v_r;
  logic                  rd_done_r;
  logic                  pend_v_r;
  logic [IDX_W-1:0]      pend_idx_r;
  logic [TAG_W-1:0]      pend_tag_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic            s1_used, s1_due, s1_report;
  logic [CD_W-1:0] cd_dec;
  logic            mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t          mem_wd;
  logic            emit;
  out_item_t       emit_d;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_used  = used_r[s1_idx_r];
  assign cd_dec   = rd_q.cd - CD_W'(1);
  assign s1_due   = s1_used && (cd_dec == '0);
  assign s1_report = s1_due && (cnt_r < CNT_W'(RESULT_CAP));

  always_comb begin
    sts.period_zero  = (item_r.task_period == '0);
    sts.cur_free     = !used_r[idx_r];
    sts.idx_last     = (idx_r == IDX_LAST);
    sts.s1_v         = s1_v_r;
    sts.s1_needs_out = s1_report && pend_v_r;
    sts.rd_done      = rd_done_r;
    sts.out_free     = out_free;
  end

  // table write port: add places at scan index, tick writes back read stage
  always_comb begin
    mem_we = 1'b0;
    mem_wa = s1_idx_r;
    mem_wd = rd_q;
    if (cmd.add_place) begin
      mem_we = 1'b1;
      mem_wa = idx_r;
      mem_wd.cd  = CD_W'(item_r.start_delay) + CD_W'(1);
      mem_wd.per = item_r.task_period;
      mem_wd.tag = item_r.task_tag;
    end else if (cmd.proc && s1_used) begin
      mem_we = 1'b1;
      mem_wd.cd = s1_due ? CD_W'(rd_q.per) : cd_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_issue) begin
      rd_q <= mem[idx_r];
    end
  end

  // result selection
  always_comb begin
    emit   = 1'b0;
    emit_d = '0;
    emit_d.fault_code  = fault_r;
    emit_d.last_of_run = 1'b1;
    if (cmd.add_zero) begin
      emit = 1'b1;
      emit_d.slot_index = SLOT_IDX_W'(TASK_SLOTS);
      emit_d.fault_code = FAULT_ZERO_PER;
    end else if (cmd.add_full) begin
      emit = 1'b1;
      emit_d.slot_index = SLOT_IDX_W'(TASK_SLOTS);
      emit_d.fault_code = FAULT_FULL;
    end else if (cmd.add_place) begin
      emit = 1'b1;
      emit_d.slot_index = SLOT_IDX_W'(idx_r);
    end else if (cmd.proc && s1_report && pend_v_r) begin
      emit = 1'b1;
      emit_d.slot_index  = SLOT_IDX_W'(pend_idx_r);
      emit_d.due_tag     = pend_tag_r;
      emit_d.due_valid   = 1'b1;
      emit_d.last_of_run = 1'b0;
    end else if (cmd.flush) begin
      emit = 1'b1;
      if (pend_v_r) begin
        emit_d.slot_index = SLOT_IDX_W'(pend_idx_r);
        emit_d.due_tag    = pend_tag_r;
        emit_d.due_valid  = 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.rd_issue) begin
      s1_idx_r <= idx_r;
    end
    if (cmd.proc && s1_report) begin
      pend_idx_r <= s1_idx_r;
      pend_tag_r <= rd_q.tag;
    end
    if (emit) begin
      out_r <= emit_d;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      fault_r     <= FAULT_NONE;
      idx_r       <= '0;
      s1_v_r      <= 1'b0;
      rd_done_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r     <= '0;
        s1_v_r    <= 1'b0;
        rd_done_r <= 1'b0;
        pend_v_r  <= 1'b0;
        cnt_r     <= '0;
        if (in_data.opcode == OP_TICK && in_data.task_busy) begin
          fault_r <= FAULT_OVERLOAD;
        end
      end
      if (cmd.add_zero) begin
        fault_r <= FAULT_ZERO_PER;
      end
      if (cmd.add_full) begin
        fault_r <= FAULT_FULL;
      end
      if (cmd.add_place) begin
        used_r[idx_r] <= 1'b1;
      end
      if (cmd.scan_next) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.rd_issue) begin
        s1_v_r <= 1'b1;
        if (idx_r == IDX_LAST) begin
          rd_done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end else if (cmd.proc) begin
        s1_v_r <= 1'b0;
      end
      if (cmd.proc && s1_report) begin
        pend_v_r <= 1'b1;
        cnt_r    <= cnt_r + CNT_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> src/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler.
// Depends on ptts_pkg; instantiates ptts_ctrl and ptts_dp.
//
// Time-triggered cooperative scheduler table. An add transaction (opcode 0)
// puts a task in the lowest free slot with countdown start_delay+1 and answers
// with one result naming the slot, or TASK_SLOTS (masked to 5 bits) when the
// period is zero (fault 3, wins) or the table is full (fault 2). A tick
// transaction (opcode 1) decrements every used countdown; each task reaching
// zero is reported in slot order and reloaded from its period, with
// last_of_run on the final result. A tick with nothing due gives one result
// with due_valid low. task_busy on a tick records an overload fault (1) before
// the tick is handled. fault_code on every result is the most recent fault.
// At most 16 due tasks are reported per tick; later due tasks still reload.
// Timing: one transaction at a time. An add's free-slot scan steps over used
// slots until it finds a free one or reaches the last slot. A tick walks the
// table memory (one read port, one write port) one slot per cycle through a
// registered read stage, unless the result channel stalls. A finished result
// sits in the output register, so the next transaction is accepted while it
// waits. The table needs no clearing pass after reset; only the used flags
// are cleared.
module periodic_task_tick_scheduler #(
  parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ptts_pkg::out_item_t out_data
);
  import ptts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle / add scan / tick walk / tick close
  ptts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, fault register and result staging register
  ptts_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
